/* rtl/core/bpc_pkg.sv */
// Shared constants, codes and types for the bandpass correction block.
// Used by bpc_div and bandpass_correction_apply; no dependencies.
package bpc_pkg;

  localparam int MAX_STATIONS_DEF = 8;
  localparam int MAX_POLS_DEF     = 2;
  localparam int MAX_IFS_DEF      = 8;
  localparam int MAX_CHANNELS_DEF = 256;
  localparam int GAIN_BITS_DEF    = 24;

  // iterative unit word width and step counts
  localparam int DIV_W      = 64;
  localparam int DIV_STEPS  = DIV_W;
  localparam int SQRT_STEPS = DIV_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  // |z|^2 threshold for |z| < 0.01 in Q32.32
  localparam logic [63:0] SMALL_LIMIT = 64'd429497;

  localparam logic [1:0] KIND_IF_LOAD  = 2'd0;
  localparam logic [1:0] KIND_TAB_LOAD = 2'd1;
  localparam logic [1:0] KIND_APPLY    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_NO_FREQ   = 2'd2;
  localparam logic [1:0] ST_LOADED    = 2'd3;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_RAW_CH   = 2'd1;
  localparam logic [1:0] REG_IFS      = 2'd2;
  localparam logic [1:0] REG_PHASE    = 2'd3;

  typedef struct packed {
    logic start;
    logic sqrt_op;
  } div_req_t;

endpackage

/* rtl/core/bandpass_correction_apply.sv */
// Bandpass correction: IF loads, gain-table loads and per-sample correction.
// Depends on bpc_pkg and bpc_div.
// Per kind: an IF load runs one 64-step divide, skipped when raw_channels_per_if
// is zero; a table load runs two 64-step divides, after a 32-step root in
// phase-only mode, and none for a gain below the threshold; an apply searches the
// IFs from the current one with index wraps, then reads the gain and multiplies.
// One item at a time; s_tready rises in the same cycle as m_tvalid.
// rst clears the sequencer, output valid, current IF and loaded flag, and sets config to its defaults.
module bandpass_correction_apply #(
  parameter int MAX_STATIONS = bpc_pkg::MAX_STATIONS_DEF,
  parameter int MAX_POLS     = bpc_pkg::MAX_POLS_DEF,
  parameter int MAX_IFS      = bpc_pkg::MAX_IFS_DEF,
  parameter int MAX_CHANNELS = bpc_pkg::MAX_CHANNELS_DEF,
  parameter int GAIN_BITS    = bpc_pkg::GAIN_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // station_id[2:0] polarization[3] position[14:4] sky_frequency_hz[54:15]
  // bandwidth_hz[86:55] lower_sideband[87] conjugate_flag[88]
  // value_re[120:89] value_im[152:121], zero above
  input  logic [159:0] s_tdata,
  input  logic [1:0]   s_tuser,   // kind
  input  logic         s_tlast,   // last_entry
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_re[31:0] result_im[63:32] matched_if[66:64] saturated[67], zero above
  output logic [71:0]  m_tdata,
  output logic [1:0]   m_tuser,   // status_code
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  import bpc_pkg::*;

  localparam int TABLE_SPAN = MAX_IFS * MAX_CHANNELS;
  localparam int GAIN_DEPTH = MAX_STATIONS * MAX_POLS * TABLE_SPAN;
  localparam int AW = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;
  localparam int IW = (MAX_IFS > 1) ? $clog2(MAX_IFS) : 1;
  localparam int NW = $clog2(MAX_IFS + 2);
  localparam int GB = GAIN_BITS;
  localparam logic [63:0] GAIN_LIM = (64'd1 << (GB - 1)) - 64'd1;

  localparam logic [4:0] S_IDLE = 5'd0,  S_IDS  = 5'd1,  S_IDW  = 5'd2,  S_IFWR = 5'd3,
                         S_SQ1  = 5'd4,  S_SQ2  = 5'd5,  S_SQ3  = 5'd6,  S_CHK  = 5'd7,
                         S_SQS  = 5'd8,  S_SQW  = 5'd9,  S_DRS  = 5'd10, S_DRW  = 5'd11,
                         S_DIS  = 5'd12, S_DIW  = 5'd13, S_TWR  = 5'd14, S_SRCH = 5'd15,
                         S_WRAP = 5'd16, S_APOS = 5'd17, S_RD   = 5'd18, S_LDG  = 5'd19,
                         S_MUL1 = 5'd20, S_MUL2 = 5'd21, S_MUL3 = 5'd22, S_MUL4 = 5'd23,
                         S_MUL5 = 5'd24, S_FIN  = 5'd25, S_DONE = 5'd26;

  // configuration
  logic [8:0]  channels_per_if;
  logic [16:0] raw_channels_per_if;
  logic [3:0]  ifs_in_use;
  logic        phase_only_mode;

  // item registers
  logic [4:0]         state;
  logic [2:0]         station;
  logic               pol;
  logic [10:0]        pos;
  logic [39:0]        freq;
  logic [31:0]        bw;
  logic               lsb;
  logic               conj;
  logic signed [31:0] vre;
  logic signed [31:0] vim;
  logic               last;

  logic [31:0]        ar, ai;
  logic [63:0]        s, r;
  logic [31:0]        delta;
  logic signed [GB-1:0] gre, gim;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] acc_re, acc_im;

  logic [NW-1:0] idx, kcnt, n, current_if;
  logic          table_loaded;
  logic [39:0]   up_f [MAX_IFS];
  logic [39:0]   lo_f [MAX_IFS];

  logic [2*GB-1:0] gmem [GAIN_DEPTH];
  logic [2*GB-1:0] gmem_rd;
  logic [AW-1:0]   gaddr;
  logic            gmem_we;

  logic signed [31:0] res_re, res_im;
  logic [1:0]         status;
  logic [2:0]         matched;
  logic               clip;

  div_req_t    dreq;
  logic [63:0] dnum, dden, dres;
  logic        ddone;

  logic          row_ok;
  logic [31:0]   row_base;
  logic [8:0]    c;
  logic          in_band;
  logic [8:0]    j;
  logic [39:0]   want;
  logic          idx_ok;
  logic [IW-1:0] idx_i;
  logic [GB-1:0] q_sat;
  logic          q_neg;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                               output logic hit);
    logic signed [63:0] sh;
    sh  = v >>> 16;
    hit = 1'b0;
    if (sh > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'sh7FFFFFFF;
    end else if (sh < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'sh80000000;
    end
    return sh[31:0];
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    ar       = vre[31] ? (~vre + 32'd1) : vre;
    ai       = vim[31] ? (~vim + 32'd1) : vim;
    row_ok   = (32'(station) < 32'(MAX_STATIONS)) && (32'(pol) < 32'(MAX_POLS));
    row_base = (32'(station) * 32'(MAX_POLS) + 32'(pol)) * 32'(TABLE_SPAN);
    c        = (32'(channels_per_if) > 32'(MAX_CHANNELS)) ? 9'(MAX_CHANNELS) : channels_per_if;
    if (lsb) begin
      in_band = (pos >= 11'd1) && (pos <= {2'b0, c});
      j       = c - pos[8:0];
    end else begin
      in_band = pos < {2'b0, c};
      j       = pos[8:0];
    end
    idx_ok = 32'(idx) < 32'(MAX_IFS);
    idx_i  = idx[IW-1:0];
    want   = lsb ? lo_f[idx_i] : up_f[idx_i];
    q_sat  = (dres > GAIN_LIM) ? GAIN_LIM[GB-1:0] : dres[GB-1:0];
    q_neg  = (state == S_DRW) ? vre[31] : (vim != 32'sd0 && !vim[31]);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ1:   begin mul_a = {1'b0, ar}; mul_b = {1'b0, ar}; end
      S_SQ2:   begin mul_a = {1'b0, ai}; mul_b = {1'b0, ai}; end
      S_MUL1:  begin mul_a = {vre[31], vre}; mul_b = 33'(gre); end
      S_MUL2:  begin mul_a = {vim[31], vim}; mul_b = 33'(gim); end
      S_MUL3:  begin mul_a = {vre[31], vre}; mul_b = 33'(gim); end
      S_MUL4:  begin mul_a = {vim[31], vim}; mul_b = 33'(gre); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // iterative unit requests
  always_comb begin
    dreq.start   = 1'b0;
    dreq.sqrt_op = 1'b0;
    dnum         = 64'd0;
    dden         = 64'd0;
    unique case (state)
      S_IDS: begin
        dreq.start = (raw_channels_per_if != 17'd0);
        dnum       = {32'd0, bw};
        dden       = {47'd0, raw_channels_per_if};
      end
      S_SQS: begin
        dreq.start   = 1'b1;
        dreq.sqrt_op = 1'b1;
        dnum         = s;
      end
      S_DRS, S_DIS: begin
        dreq.start = 1'b1;
        if (phase_only_mode) begin
          dnum = ({32'd0, (state == S_DRS) ? ar : ai} << 16) + {1'b0, r[63:1]};
          dden = r;
        end else begin
          dnum = {(state == S_DRS) ? ar : ai, 32'd0} + {1'b0, s[63:1]};
          dden = s;
        end
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  bpc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (dreq),
    .num    (dnum),
    .den    (dden),
    .done   (ddone),
    .result (dres)
  );

  assign gmem_we = (state == S_TWR) && row_ok && (32'(pos) < 32'(TABLE_SPAN));

  always_ff @(posedge clk) begin
    if (gmem_we) begin
      gmem[gaddr] <= {gim, gre};
    end
    gmem_rd <= gmem[gaddr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    logic hit_re;
    logic hit_im;
    if (rst) begin
      state               <= S_IDLE;
      m_tvalid            <= 1'b0;
      current_if          <= '0;
      table_loaded        <= 1'b0;
      channels_per_if     <= 9'd256;
      raw_channels_per_if <= 17'd256;
      ifs_in_use          <= 4'd8;
      phase_only_mode     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CHANNELS: channels_per_if     <= cfg_data[8:0];
          REG_RAW_CH:   raw_channels_per_if <= cfg_data;
          REG_IFS:      ifs_in_use          <= cfg_data[3:0];
          REG_PHASE:    phase_only_mode     <= cfg_data[0];
          default:      phase_only_mode     <= phase_only_mode;
        endcase
      end
      // S_DONE reloads the output register itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            station <= s_tdata[2:0];
            pol     <= s_tdata[3];
            pos     <= s_tdata[14:4];
            freq    <= s_tdata[54:15];
            bw      <= s_tdata[86:55];
            lsb     <= s_tdata[87];
            conj    <= s_tdata[88];
            vre     <= s_tdata[120:89];
            vim     <= s_tdata[152:121];
            last    <= s_tlast;
            res_re  <= '0;
            res_im  <= '0;
            status  <= ST_OK;
            matched <= '0;
            clip    <= 1'b0;
            n       <= (32'(ifs_in_use) > 32'(MAX_IFS)) ? NW'(MAX_IFS) : NW'(ifs_in_use);
            idx     <= current_if;
            kcnt    <= '0;
            unique case (s_tuser)
              KIND_IF_LOAD:  state <= S_IDS;
              KIND_TAB_LOAD: state <= S_SQ1;
              KIND_APPLY:    state <= S_SRCH;
              default:       state <= S_DONE;
            endcase
          end
        end
        S_IDS: begin
          delta <= 32'd0;
          state <= (raw_channels_per_if != 17'd0) ? S_IDW : S_IFWR;
        end
        S_IDW: begin
          if (ddone) begin
            delta <= dres[31:0];
            state <= S_IFWR;
          end
        end
        S_IFWR: begin
          if (32'(pos) < 32'(MAX_IFS)) begin
            up_f[pos[IW-1:0]] <= freq;
            lo_f[pos[IW-1:0]] <= freq + {8'd0, bw} - {8'd0, delta};
          end
          status <= ST_LOADED;
          state  <= S_DONE;
        end
        S_SQ1: begin
          gaddr <= AW'(row_base + 32'(pos));
          state <= S_SQ2;
        end
        S_SQ2: begin
          s     <= prod[63:0];
          state <= S_SQ3;
        end
        S_SQ3: begin
          s     <= s + prod[63:0];
          state <= S_CHK;
        end
        S_CHK: begin
          gre <= '0;
          gim <= '0;
          if (s < SMALL_LIMIT) begin
            state <= S_TWR;
          end else if (phase_only_mode) begin
            state <= S_SQS;
          end else begin
            state <= S_DRS;
          end
        end
        S_SQS: state <= S_SQW;
        S_SQW: begin
          if (ddone) begin
            r     <= dres;
            state <= S_DRS;
          end
        end
        S_DRS: state <= S_DRW;
        S_DRW: begin
          if (ddone) begin
            gre   <= q_neg ? -$signed(q_sat) : $signed(q_sat);
            state <= S_DIS;
          end
        end
        S_DIS: state <= S_DIW;
        S_DIW: begin
          if (ddone) begin
            gim   <= q_neg ? -$signed(q_sat) : $signed(q_sat);
            state <= S_TWR;
          end
        end
        S_TWR: begin
          if (last) begin
            table_loaded <= 1'b1;
          end
          status <= ST_LOADED;
          state  <= S_DONE;
        end
        S_SRCH: begin
          if (!table_loaded) begin
            status <= ST_NOT_READY;
            state  <= S_DONE;
          end else if (n == '0) begin
            status <= ST_NO_FREQ;
            state  <= S_DONE;
          end else if (idx_ok && want == freq) begin
            current_if <= idx;
            matched    <= 3'(idx);
            state      <= S_APOS;
          end else begin
            idx   <= idx + 1'b1;
            kcnt  <= kcnt + 1'b1;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          // index wraps modulo the IF count; a stale index may need several passes
          if (idx >= n) begin
            idx <= idx - n;
          end else if (kcnt == n) begin
            current_if <= idx;
            status     <= ST_NO_FREQ;
            state      <= S_DONE;
          end else begin
            state <= S_SRCH;
          end
        end
        S_APOS: begin
          gaddr <= AW'(row_base + 32'(idx) * 32'(c) + 32'(j));
          gre   <= '0;
          gim   <= '0;
          if (!in_band) begin
            res_re <= vre;
            res_im <= vim;
            state  <= S_DONE;
          end else begin
            state <= row_ok ? S_RD : S_MUL1;
          end
        end
        S_RD: state <= S_LDG;
        S_LDG: begin
          gre   <= gmem_rd[GB-1:0];
          gim   <= (conj != lsb) ? -$signed(gmem_rd[2*GB-1:GB]) : $signed(gmem_rd[2*GB-1:GB]);
          state <= S_MUL1;
        end
        S_MUL1: begin
          // missing slot: zero gain, conjugation moot
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc_re <= prod[63:0];
          state  <= S_MUL3;
        end
        S_MUL3: begin
          acc_re <= acc_re - prod[63:0];
          state  <= S_MUL4;
        end
        S_MUL4: begin
          acc_im <= prod[63:0];
          state  <= S_MUL5;
        end
        S_MUL5: begin
          acc_im <= acc_im + prod[63:0];
          state  <= S_FIN;
        end
        S_FIN: begin
          res_re <= sat32(acc_re, hit_re);
          res_im <= sat32(acc_im, hit_im);
          clip   <= hit_re | hit_im;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, clip, matched, res_im, res_re};
            m_tuser  <= status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/bpc_div.sv */
// Iterative divide / square-root unit, one bit (or bit pair) per cycle.
// Depends on bpc_pkg.
module bpc_div (
  input  logic               clk,
  input  logic               rst,
  input  bpc_pkg::div_req_t  req,
  input  logic [63:0]        num,
  input  logic [63:0]        den,
  output logic               done,
  output logic [63:0]        result
);
  import bpc_pkg::*;

  logic             busy;
  logic             sqrt_op;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      acc;   // remainder, or radicand left
  logic [63:0]      quo;   // quotient (shifting in), or root
  logic [63:0]      dv;    // divisor, or current bit
  logic [64:0]      rem_sh;
  logic [64:0]      diff;
  logic [64:0]      trial;
  logic             ge;
  logic             sq_ge;
  logic             last_step;

  always_comb begin
    rem_sh    = {acc, quo[63]};
    diff      = rem_sh - {1'b0, dv};
    ge        = rem_sh >= {1'b0, dv};
    trial     = {1'b0, quo} + {1'b0, dv};
    sq_ge     = {1'b0, acc} >= trial;
    last_step = sqrt_op ? (cnt == CNT_W'(SQRT_STEPS - 1)) : (cnt == CNT_W'(DIV_STEPS - 1));
  end

  assign result = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        sqrt_op <= req.sqrt_op;
        cnt     <= '0;
        acc     <= req.sqrt_op ? num : 64'd0;
        quo     <= req.sqrt_op ? 64'd0 : num;
        dv      <= req.sqrt_op ? (64'd1 << 62) : den;
      end else if (busy) begin
        if (sqrt_op) begin
          if (sq_ge) begin
            acc <= acc - trial[63:0];
            quo <= (quo >> 1) + dv;
          end else begin
            quo <= quo >> 1;
          end
          dv <= dv >> 2;
        end else begin
          acc <= ge ? diff[63:0] : rem_sh[63:0];
          quo <= {quo[62:0], ge};
        end
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
